>>> hw/rtl/binary_thinning_subpass_defines.svh
// Assertion macros used by the thinning sub-pass top level.
`ifndef BINARY_THINNING_SUBPASS_DEFINES_SVH
`define BINARY_THINNING_SUBPASS_DEFINES_SVH
`ifndef SYNTHESIS
`define BTS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");
`define BTS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define BTS_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define BTS_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

>>> hw/rtl/bts_pkg.sv
// Package: constants, types and decision functions of the thinning sub-pass.
package bts_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int COORD_W    = 10;
    localparam int DIM_W      = 11;
    localparam int ADDR_W     = $clog2(MAX_WIDTH);
    localparam int CFG_IDX_W  = 2;
    localparam logic [DIM_W-1:0] MAX_W_DIM = DIM_W'(MAX_WIDTH);
    localparam logic [DIM_W-1:0] MAX_H_DIM = DIM_W'(MAX_HEIGHT);
    localparam logic [DIM_W-1:0] MIN_DIM   = DIM_W'(3);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH   = 2'd0,
        CFG_IMAGE_HEIGHT  = 2'd1,
        CFG_SUB_ITERATION = 2'd2
    } bts_cfg_idx_t;

    typedef struct packed {
        logic               px;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic               eol;
        logic               lastrow;
        logic               interior;
    } bts_item_t;

    // mask bit order: (r-1,c-1), (r,c-1), (r-1,c), (r,c)
    typedef struct packed {
        logic [3:0]         mask;
        logic               pix_a;
        logic               rem_a;
        logic               pix_b;
        logic               pix_c;
        logic               pix_d;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
    } bts_group_t;

    function automatic logic [DIM_W-1:0] bts_clamp(logic [DIM_W-1:0] v,
                                                   logic [DIM_W-1:0] hi);
        logic [DIM_W-1:0] res;
        if (v < MIN_DIM) begin
            res = MIN_DIM;
        end else if (v > hi) begin
            res = hi;
        end else begin
            res = v;
        end
        return res;
    endfunction

    function automatic logic bts_clears(logic [8:0] win, logic sub);
        logic [7:0] p;
        logic [3:0] a;
        logic [3:0] b;
        logic       m1;
        logic       m2;
        p = {win[0], win[3], win[6], win[7], win[8], win[5], win[2], win[1]};
        a = '0;
        b = '0;
        for (int i = 0; i < 8; i++) begin
            b = b + {3'b000, p[i]};
            if (!p[i] && p[3'(i + 1)]) begin
                a = a + 4'd1;
            end
        end
        if (!sub) begin
            m1 = p[0] & p[2] & p[4];
            m2 = p[2] & p[4] & p[6];
        end else begin
            m1 = p[0] & p[2] & p[6];
            m2 = p[0] & p[4] & p[6];
        end
        return win[4] && (a == 4'd1) && (b >= 4'd2) && (b <= 4'd6) && !m1 && !m2;
    endfunction

endpackage

>>> hw/rtl/bts_line_store.sv
// Two-row line store: {upper, middle} bits per column, registered read.
module bts_line_store (
    input  logic                      aclk,
    input  logic                      rd_en,
    input  logic [bts_pkg::ADDR_W-1:0] rd_addr,
    output logic [1:0]                rd_data,
    input  logic                      wr_en,
    input  logic [bts_pkg::ADDR_W-1:0] wr_addr,
    input  logic [1:0]                wr_data
);
    import bts_pkg::*;

    logic [1:0] mem [MAX_WIDTH];
    logic [1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> hw/rtl/bts_window.sv
// 3x3 window shift and removal decision; builds the result group of one pixel.
module bts_window (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                advance,
    input  bts_pkg::bts_item_t  item,
    input  logic [1:0]          ram_data,
    input  logic                sub_iteration,
    output logic [1:0]          wr_data,
    output bts_pkg::bts_group_t group
);
    import bts_pkg::*;

    logic [8:0] win_reg;
    logic [8:0] win_next;
    logic       up;
    logic       mid;
    logic       rem;
    logic       has_a;
    logic       has_c;

    assign up  = ram_data[1];
    assign mid = ram_data[0];

    assign win_next = ({1'b0, win_reg[8:1]} & 9'h1DB)
                    | {6'd0, up, 2'd0} | {3'd0, mid, 5'd0} | {item.px, 8'd0};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_reg <= '0;
        end else if (advance) begin
            win_reg <= win_next;
        end
    end

    assign wr_data = {mid, item.px};
    assign rem     = item.interior & bts_clears(win_next, sub_iteration);
    assign has_a   = (item.row != '0) && (item.col != '0);
    assign has_c   = (item.row != '0) && item.eol;

    always_comb begin
        group.mask  = {has_c & item.lastrow, has_c, has_a & item.lastrow, has_a};
        group.pix_a = win_next[4] & ~rem;
        group.rem_a = rem;
        group.pix_b = win_next[7];
        group.pix_c = mid;
        group.pix_d = item.px;
        group.row   = item.row;
        group.col   = item.col;
    end

endmodule

>>> hw/rtl/bts_emitter.sv
// Result buffer: holds one pixel's result group and sends it one transfer at a time.
module bts_emitter (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       load,
    input  bts_pkg::bts_group_t        group,
    output logic                       free,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic                       m_pixel_out,
    output logic                       m_removed,
    output logic [bts_pkg::COORD_W-1:0] m_out_row,
    output logic [bts_pkg::COORD_W-1:0] m_out_col,
    output logic                       m_last
);
    import bts_pkg::*;

    logic [3:0]         mask_reg;
    logic [3:0]         mask_next;
    bts_group_t         buf_reg;
    logic [3:0]         cur;
    logic [3:0]         rest;
    logic               xfer;
    logic [COORD_W-1:0] row_m1;
    logic [COORD_W-1:0] col_m1;

    always_comb begin
        priority if (mask_reg[0]) begin
            cur = 4'b0001;
        end else if (mask_reg[1]) begin
            cur = 4'b0010;
        end else if (mask_reg[2]) begin
            cur = 4'b0100;
        end else begin
            cur = {mask_reg[3], 3'b000};
        end
    end

    assign rest   = mask_reg & ~cur;
    assign xfer   = m_valid && m_ready;
    assign free   = (mask_reg == '0) || (m_ready && rest == '0);
    assign row_m1 = buf_reg.row - COORD_W'(1);
    assign col_m1 = buf_reg.col - COORD_W'(1);

    always_comb begin
        mask_next = mask_reg;
        if (xfer) begin
            mask_next = rest;
        end
        if (load && free) begin
            mask_next = group.mask;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_reg <= '0;
        end else begin
            mask_reg <= mask_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load && free) begin
            buf_reg <= group;
        end
    end

    assign m_valid = (mask_reg != '0);
    assign m_last  = (rest == '0);

    always_comb begin
        unique case (cur)
            4'b0001: begin
                m_pixel_out = buf_reg.pix_a;
                m_removed   = buf_reg.rem_a;
                m_out_row   = row_m1;
                m_out_col   = col_m1;
            end
            4'b0010: begin
                m_pixel_out = buf_reg.pix_b;
                m_removed   = 1'b0;
                m_out_row   = buf_reg.row;
                m_out_col   = col_m1;
            end
            4'b0100: begin
                m_pixel_out = buf_reg.pix_c;
                m_removed   = 1'b0;
                m_out_row   = row_m1;
                m_out_col   = buf_reg.col;
            end
            default: begin
                m_pixel_out = buf_reg.pix_d;
                m_removed   = 1'b0;
                m_out_row   = buf_reg.row;
                m_out_col   = buf_reg.col;
            end
        endcase
    end

endmodule

>>> hw/rtl/binary_thinning_subpass.sv
// Top level of one Zhang-Suen thinning sub-pass over a raster-order binary stream.
// A pixel's results pass the stage-1 item register and then the result buffer before transfer.
// Throughput: one pixel per cycle while each pixel yields at most one result and results
// are accepted; a pixel yielding n results (up to 4, at row ends and on the last row) holds
// the result buffer until all n have transferred. Line store: one 1024x2 RAM, read then written.
// Reset: counters, window and control clear; line store contents are not cleared.
`include "binary_thinning_subpass_defines.svh"
module binary_thinning_subpass (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic                         s_pixel_in,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic                         m_pixel_out,
    output logic                         m_removed,
    output logic [bts_pkg::COORD_W-1:0]   m_out_row,
    output logic [bts_pkg::COORD_W-1:0]   m_out_col,
    output logic                         m_last,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [bts_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bts_pkg::DIM_W-1:0]     cfg_data
);
    import bts_pkg::*;

    logic [DIM_W-1:0]   width_reg;
    logic [DIM_W-1:0]   height_reg;
    logic               sub_reg;
    logic [COORD_W-1:0] row_reg;
    logic [COORD_W-1:0] row_next;
    logic [COORD_W-1:0] col_reg;
    logic [COORD_W-1:0] col_next;
    logic               s1_valid_reg;
    logic               s1_valid_next;
    bts_item_t          s1_item_reg;
    bts_item_t          item_in;
    logic [DIM_W-1:0]   w_m1;
    logic [DIM_W-1:0]   h_m1;
    logic [DIM_W-1:0]   col_ext;
    logic [DIM_W-1:0]   row_ext;
    logic               eol;
    logic               lastrow;
    logic               s_xfer;
    logic               advance;
    logic               emit_free;
    logic [1:0]         ram_rd;
    logic [1:0]         ram_wr;
    bts_group_t         group;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= MAX_W_DIM;
            height_reg <= MAX_H_DIM;
            sub_reg    <= 1'b0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_IMAGE_WIDTH:   width_reg  <= cfg_data;
                CFG_IMAGE_HEIGHT:  height_reg <= cfg_data;
                CFG_SUB_ITERATION: sub_reg    <= cfg_data[0];
                default: ;
            endcase
        end
    end

    assign w_m1    = bts_clamp(width_reg, MAX_W_DIM) - DIM_W'(1);
    assign h_m1    = bts_clamp(height_reg, MAX_H_DIM) - DIM_W'(1);
    assign col_ext = {1'b0, col_reg};
    assign row_ext = {1'b0, row_reg};
    assign eol     = col_ext >= w_m1;
    assign lastrow = row_ext >= h_m1;

    assign advance = s1_valid_reg && emit_free;
    assign s_ready = !s1_valid_reg || advance;
    assign s_xfer  = s_valid && s_ready;

    always_comb begin
        item_in.px       = s_pixel_in;
        item_in.row      = row_reg;
        item_in.col      = col_reg;
        item_in.eol      = eol;
        item_in.lastrow  = lastrow;
        item_in.interior = (row_reg >= COORD_W'(2)) && (row_ext <= h_m1)
                        && (col_reg >= COORD_W'(2)) && (col_ext <= w_m1);
    end

    always_comb begin
        row_next      = row_reg;
        col_next      = col_reg;
        s1_valid_next = s1_valid_reg;
        if (advance) begin
            s1_valid_next = 1'b0;
        end
        if (s_xfer) begin
            s1_valid_next = 1'b1;
            if (eol) begin
                col_next = '0;
                row_next = lastrow ? '0 : row_reg + COORD_W'(1);
            end else begin
                col_next = col_reg + COORD_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg      <= '0;
            col_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end else begin
            row_reg      <= row_next;
            col_reg      <= col_next;
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            s1_item_reg <= item_in;
        end
    end

    bts_line_store u_line_store (
        .aclk    (aclk),
        .rd_en   (s_xfer),
        .rd_addr (col_reg[ADDR_W-1:0]),
        .rd_data (ram_rd),
        .wr_en   (advance),
        .wr_addr (s1_item_reg.col[ADDR_W-1:0]),
        .wr_data (ram_wr)
    );

    bts_window u_window (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .advance       (advance),
        .item          (s1_item_reg),
        .ram_data      (ram_rd),
        .sub_iteration (sub_reg),
        .wr_data       (ram_wr),
        .group         (group)
    );

    bts_emitter u_emitter (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .load        (advance),
        .group       (group),
        .free        (emit_free),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_pixel_out (m_pixel_out),
        .m_removed   (m_removed),
        .m_out_row   (m_out_row),
        .m_out_col   (m_out_col),
        .m_last      (m_last)
    );

    `BTS_ASSERT_NXT(a_s1_hold, aclk, aresetn, s1_valid_reg && !advance, s1_valid_reg && $stable(s1_item_reg))
    `BTS_ASSERT_NXT(a_eol_wrap, aclk, aresetn, s_xfer && eol, col_reg == '0)
    `BTS_ASSERT_IMP(a_s1_geom, aclk, aresetn, s1_valid_reg && s1_item_reg.eol, s1_item_reg.col >= COORD_W'(2))

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for the thinning sub-pass: directed cases and random binary frames against a bit-true predictor.
module tb_top;
    import bts_pkg::*;

    localparam int LIMIT_CYCLES  = 200000;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 150;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    typedef struct packed {
        logic               pix;
        logic               rem;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic               last;
    } thin_pixel_t;

    class thin_scoreboard;
        int unsigned width_reg;
        int unsigned height_reg;
        bit          sub_sel;
        bit          upper_row [MAX_WIDTH];
        bit          middle_row [MAX_WIDTH];
        bit [8:0]    window;
        int unsigned row_cnt;
        int unsigned col_cnt;
        thin_pixel_t pixels_q[$];
        int          errors;
        int          pixels;
        int          results;
        int          cleared;
        int          writes;

        function new();
            width_reg  = MAX_WIDTH;
            height_reg = MAX_HEIGHT;
            sub_sel    = 1'b0;
            window     = '0;
            row_cnt    = 0;
            col_cnt    = 0;
            errors     = 0;
            pixels     = 0;
            results    = 0;
            cleared    = 0;
            writes     = 0;
        endfunction

        function int unsigned fit(int unsigned v, int unsigned hi);
            return (v < 3) ? 3 : ((v > hi) ? hi : v);
        endfunction

        function int pending();
            return pixels_q.size();
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] data);
            writes++;
            case (idx)
                CFG_IMAGE_WIDTH:   width_reg = data;
                CFG_IMAGE_HEIGHT:  height_reg = data;
                CFG_SUB_ITERATION: sub_sel = data[0];
                default: ;
            endcase
        endfunction

        // ring order N, NE, E, SE, S, SW, W, NW
        function bit thins_centre(bit [8:0] win);
            bit ring [8];
            int trans;
            int ones;
            bit m1;
            bit m2;
            ring = '{win[1], win[2], win[5], win[8], win[7], win[6], win[3], win[0]};
            trans = 0;
            ones = 0;
            for (int i = 0; i < 8; i++) begin
                ones += ring[i];
                if (!ring[i] && ring[(i + 1) % 8]) trans++;
            end
            if (!sub_sel) begin
                m1 = ring[0] & ring[2] & ring[4];
                m2 = ring[2] & ring[4] & ring[6];
            end else begin
                m1 = ring[0] & ring[2] & ring[6];
                m2 = ring[0] & ring[4] & ring[6];
            end
            return win[4] && trans == 1 && ones >= 2 && ones <= 6 && !m1 && !m2;
        endfunction

        function int unsigned pixels_to_frame_end();
            int unsigned w;
            int unsigned h;
            int unsigned n;
            w = fit(width_reg, MAX_WIDTH);
            h = fit(height_reg, MAX_HEIGHT);
            n = (col_cnt >= w - 1) ? 1 : w - col_cnt;
            if (row_cnt < h - 1) n += (h - 1 - row_cnt) * w;
            return n;
        endfunction

        function void note_pixel(bit px);
            int unsigned w;
            int unsigned h;
            int unsigned r;
            int unsigned c;
            bit          up;
            bit          mid;
            bit          eol;
            bit          lastrow;
            bit          interior;
            bit          rem;
            thin_pixel_t group[$];
            pixels++;
            w = fit(width_reg, MAX_WIDTH);
            h = fit(height_reg, MAX_HEIGHT);
            r = row_cnt;
            c = col_cnt;
            eol = (c >= w - 1);
            lastrow = (r >= h - 1);
            up = 1'b0;
            mid = 1'b0;
            if (c < MAX_WIDTH) begin
                up = upper_row[c];
                mid = middle_row[c];
                upper_row[c] = mid;
                middle_row[c] = px;
            end
            window = ((window >> 1) & 9'h1DB) | (9'(up) << 2) | (9'(mid) << 5) | (9'(px) << 8);
            if (r >= 1) begin
                if (c >= 1) begin
                    interior = (r >= 2 && r <= h - 1 && c >= 2 && c <= w - 1);
                    rem = interior ? thins_centre(window) : 1'b0;
                    if (rem) cleared++;
                    group.push_back(thin_pixel_t'{window[4] & ~rem, rem,
                                                  COORD_W'(r - 1), COORD_W'(c - 1), 1'b0});
                    if (lastrow) begin
                        group.push_back(thin_pixel_t'{window[7], 1'b0,
                                                      COORD_W'(r), COORD_W'(c - 1), 1'b0});
                    end
                end
                if (eol) begin
                    group.push_back(thin_pixel_t'{mid, 1'b0, COORD_W'(r - 1), COORD_W'(c), 1'b0});
                    if (lastrow) begin
                        group.push_back(thin_pixel_t'{px, 1'b0, COORD_W'(r), COORD_W'(c), 1'b0});
                    end
                end
            end
            if (group.size() > 0) group[group.size() - 1].last = 1'b1;
            foreach (group[i]) pixels_q.push_back(group[i]);
            if (eol) begin
                col_cnt = 0;
                row_cnt = lastrow ? 0 : (r + 1) & 14'h3FFF;
            end else begin
                col_cnt = (c + 1) & 14'h3FFF;
            end
        endfunction

        function void check_result(thin_pixel_t got);
            thin_pixel_t want;
            results++;
            if (pixels_q.size() == 0) begin
                $error("unexpected result transfer: row %0d col %0d", got.row, got.col);
                errors++;
                return;
            end
            want = pixels_q.pop_front();
            if (got.pix !== want.pix) begin
                $error("pixel_out: expected %0d, actual %0d", want.pix, got.pix);
                errors++;
            end
            if (got.rem !== want.rem) begin
                $error("removed: expected %0d, actual %0d", want.rem, got.rem);
                errors++;
            end
            if (got.row !== want.row) begin
                $error("out_row: expected %0d, actual %0d", want.row, got.row);
                errors++;
            end
            if (got.col !== want.col) begin
                $error("out_col: expected %0d, actual %0d", want.col, got.col);
                errors++;
            end
            if (got.last !== want.last) begin
                $error("last: expected %0d, actual %0d", want.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic                 s_pixel_in = 1'b0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic                 m_pixel_out;
    logic                 m_removed;
    logic [COORD_W-1:0]   m_out_row;
    logic [COORD_W-1:0]   m_out_col;
    logic                 m_last;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [DIM_W-1:0]     cfg_data = '0;

    thin_scoreboard sb;
    int             tx_idle_pct = 0;
    int             rx_idle_pct = 0;
    bit             hold_go = 1'b0;
    bit             hold_seen = 1'b0;
    int             hold_left = 0;
    int             cycles = 0;

    binary_thinning_subpass i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_pixel_in  (s_pixel_in),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_pixel_out (m_pixel_out),
        .m_removed   (m_removed),
        .m_out_row   (m_out_row),
        .m_out_col   (m_out_col),
        .m_last      (m_last),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready) sb.set_reg(cfg_index, cfg_data);
            if (s_valid && s_ready) sb.note_pixel(s_pixel_in);
            if (m_valid && m_ready) begin
                sb.check_result(thin_pixel_t'{m_pixel_out, m_removed, m_out_row,
                                              m_out_col, m_last});
            end
        end
    end

    // result side: random backpressure plus one long hold-off
    always @(posedge aclk) begin
        if (hold_go && !hold_seen) begin
            hold_seen <= 1'b1;
            hold_left <= HOLD_CYCLES;
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles, sb.pending());
            $display("end of test: mismatches");
            $finish;
        end
    end

    task automatic send_pixel(input bit px);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_pixel_in <= px;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // wait until every expected result has arrived, then let the pipeline empty
    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic random_frames(input int unsigned quota);
        int unsigned sent;
        int unsigned frame_px;
        int unsigned k;
        int unsigned dens;
        int unsigned rest;
        bit          need_cfg;
        sent = 0;
        frame_px = 0;
        need_cfg = 1'b1;
        while (sent < quota) begin
            if (need_cfg || $urandom_range(0, 2) != 0) begin
                settle();
                write_reg(CFG_IMAGE_WIDTH, ($urandom_range(0, 9) == 0) ?
                          DIM_W'($urandom_range(0, 2)) : DIM_W'($urandom_range(3, 9)));
                write_reg(CFG_IMAGE_HEIGHT, ($urandom_range(0, 9) == 0) ?
                          DIM_W'($urandom_range(0, 2)) : DIM_W'($urandom_range(3, 6)));
                write_reg(CFG_SUB_ITERATION, DIM_W'($urandom));
                frame_px = sb.pixels_to_frame_end();
                need_cfg = 1'b0;
            end
            dens = $urandom_range(10, 95);
            if ($urandom_range(0, 3) == 0) begin
                // disturb the frame: register write while the frame is open
                k = $urandom_range(1, frame_px - 1);
                repeat (k) send_pixel($urandom_range(0, 99) < dens);
                settle();
                case ($urandom_range(0, 3))
                    0: write_reg(CFG_IMAGE_HEIGHT, DIM_W'($urandom_range(0, 6)));
                    1: write_reg(CFG_IMAGE_WIDTH,
                                 DIM_W'($urandom_range(0, sb.fit(sb.width_reg, MAX_WIDTH))));
                    2: write_reg(CFG_SUB_ITERATION, DIM_W'($urandom));
                    default: write_reg(CFG_SPARE, DIM_W'($urandom));
                endcase
                rest = sb.pixels_to_frame_end();
                repeat (rest) send_pixel($urandom_range(0, 99) < dens);
                sent += k + rest;
                need_cfg = 1'b1;
            end else begin
                repeat (frame_px) send_pixel($urandom_range(0, 99) < dens);
                sent += frame_px;
            end
        end
    endtask

    initial begin
        bit shape [9];
        sb = new();
        shape = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1};
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // row 0 at full width, then shrink the width under an open row
        write_reg(CFG_IMAGE_HEIGHT, 11'h7FF);
        send_pixel(1'b1);
        send_pixel(1'b0);
        send_pixel(1'b1);
        send_pixel(1'b1);
        settle();
        write_reg(CFG_IMAGE_WIDTH, 11'h7FF);
        write_reg(CFG_IMAGE_WIDTH, 11'h000);
        send_pixel(1'b1);
        send_pixel(1'b1);
        send_pixel(1'b1);
        send_pixel(1'b1);
        send_pixel(1'b0);
        send_pixel(1'b1);
        send_pixel(1'b1);
        // height below the current row turns it into the last row
        settle();
        write_reg(CFG_IMAGE_HEIGHT, 11'd1);
        write_reg(CFG_SPARE, 11'h7FF);
        send_pixel(1'b1);
        send_pixel(1'b0);
        send_pixel(1'b1);
        // vertical bar, centre cleared only in the second sub-pass
        settle();
        write_reg(CFG_IMAGE_HEIGHT, 11'd3);
        write_reg(CFG_SUB_ITERATION, 11'h401);
        foreach (shape[i]) send_pixel(shape[i]);

        tx_idle_pct = 33;
        rx_idle_pct <= 84;
        random_frames(40);

        tx_idle_pct = 84;
        rx_idle_pct <= 33;
        random_frames(40);

        // long result-side stall while pixels keep coming
        settle();
        tx_idle_pct = 0;
        rx_idle_pct <= 0;
        write_reg(CFG_IMAGE_WIDTH, 11'd8);
        write_reg(CFG_IMAGE_HEIGHT, 11'd6);
        write_reg(CFG_SUB_ITERATION, 11'd0);
        hold_go <= 1'b1;
        repeat (48) send_pixel($urandom_range(0, 1));
        random_frames(20);

        settle();
        $display("run: %0d pixels in, %0d results checked, %0d cleared, %0d register writes",
                 sb.pixels, sb.results, sb.cleared, sb.writes);
        $display("idle mixes on both sides, mid-frame register writes and one long output stall");
        if (sb.errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
